// ----- sv/rffr_pkg.sv -----
package rffr_pkg;

	localparam logic [7:0] SUM_SEED = 8'h55;
	localparam logic [7:0] TYPE_STATUS = 8'h02;
	localparam logic [7:0] TYPE_BULK = 8'h08;
	localparam logic [7:0] TYPE_ANNOUNCE = 8'h03;
	localparam logic [7:0] STATUS_CMD = 8'h06;
	localparam logic [4:0] LEN_STATUS = 5'd10;
	localparam logic [4:0] LEN_BULK = 5'd22;
	localparam logic [15:0] PERIOD_RESET = 16'd2000;
	localparam logic [3:0] LIMIT_RESET = 4'd3;

	localparam logic REG_PROBE_PERIOD = 1'b0;
	localparam logic REG_MISS_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_STATUS_OK = 3'd1,
		EV_STATUS_BAD = 3'd2,
		EV_BULK_OK = 3'd3,
		EV_BULK_BAD = 3'd4,
		EV_ANNOUNCE = 3'd5,
		EV_UNKNOWN = 3'd6
	} event_t;

	typedef struct packed {
		logic step;
		logic abort;
	} frame_ctl_t;

	typedef struct packed {
		event_t ev;
		logic status_ok;
		logic announce;
	} frame_res_t;

endpackage

// ----- sv/rffr_item_if.sv -----
interface rffr_item_if;
	logic valid;
	logic ready;
	logic kind;
	logic [7:0] rx_byte;

	modport source(output valid, output kind, output rx_byte, input ready);
	modport sink(input valid, input kind, input rx_byte, output ready);
endinterface

// ----- sv/rffr_result_if.sv -----
interface rffr_result_if;
	logic valid;
	logic ready;
	logic [2:0] frame_event;
	logic alive;
	logic send_probe;
	logic link_lost;

	modport source(output valid, output frame_event, output alive, output send_probe,
		output link_lost, input ready);
	modport sink(input valid, input frame_event, input alive, input send_probe,
		input link_lost, output ready);
endinterface

// ----- sv/rffr_frame.sv -----
module rffr_frame (
	input logic clk,
	input logic arst_n,
	input rffr_pkg::frame_ctl_t ctl,
	input logic [7:0] rx_byte,
	output rffr_pkg::frame_res_t res
);

	logic [4:0] count_q;
	logic [7:0] type_q;
	logic [7:0] sum_q;
	logic guards_q;

	logic [4:0] count_d;
	logic [7:0] type_d;
	logic [7:0] sum_d;
	logic guards_d;
	logic in_frame;
	logic is_status;
	logic last;
	logic ok;

	always_comb begin
		count_d = count_q;
		type_d = type_q;
		sum_d = sum_q;
		guards_d = guards_q;
		res.ev = rffr_pkg::EV_NONE;
		res.status_ok = 1'b0;
		res.announce = 1'b0;
		is_status = (type_q == rffr_pkg::TYPE_STATUS);
		in_frame = (count_q != 5'd0) && (is_status || type_q == rffr_pkg::TYPE_BULK);
		last = is_status ? (count_q >= rffr_pkg::LEN_STATUS - 5'd1)
			: (count_q >= rffr_pkg::LEN_BULK - 5'd1);
		ok = guards_q && (sum_q == rx_byte);
		if (!in_frame) begin
			type_d = rx_byte;
			sum_d = rffr_pkg::SUM_SEED - rx_byte;
			if (rx_byte == rffr_pkg::TYPE_STATUS || rx_byte == rffr_pkg::TYPE_BULK) begin
				count_d = 5'd1;
				guards_d = 1'b1;
			end else begin
				count_d = 5'd0;
				guards_d = 1'b0;
				if (rx_byte == rffr_pkg::TYPE_ANNOUNCE) begin
					res.ev = rffr_pkg::EV_ANNOUNCE;
					res.announce = 1'b1;
				end else begin
					res.ev = rffr_pkg::EV_UNKNOWN;
				end
			end
		end else if (!last) begin
			if (is_status && count_q == 5'd1 && rx_byte != rffr_pkg::STATUS_CMD) begin
				guards_d = 1'b0;
			end
			if (is_status && count_q == 5'd2 && rx_byte != 8'd0) begin
				guards_d = 1'b0;
			end
			sum_d = sum_q - rx_byte;
			count_d = count_q + 5'd1;
		end else begin
			if (is_status) begin
				res.ev = ok ? rffr_pkg::EV_STATUS_OK : rffr_pkg::EV_STATUS_BAD;
				res.status_ok = ok;
			end else begin
				res.ev = ok ? rffr_pkg::EV_BULK_OK : rffr_pkg::EV_BULK_BAD;
			end
			count_d = 5'd0;
			sum_d = rffr_pkg::SUM_SEED;
			guards_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 5'd0;
			type_q <= 8'd0;
			sum_q <= rffr_pkg::SUM_SEED;
			guards_q <= 1'b0;
		end else if (ctl.abort) begin
			count_q <= 5'd0;
			sum_q <= rffr_pkg::SUM_SEED;
			guards_q <= 1'b0;
		end else if (ctl.step) begin
			count_q <= count_d;
			type_q <= type_d;
			sum_q <= sum_d;
			guards_q <= guards_d;
		end
	end

endmodule

// ----- sv/rf_frame_receiver_with_probe_unit.sv -----
// Frame receiver with a periodic link probe.
// The items channel carries one word per cycle while ready is high: either a
// received UART byte (kind 0) or a probe tick (kind 1). Every accepted word
// produces exactly one word on the results channel, holding the frame event,
// the alive flag after that word, a probe request and a link-lost flag.
// The result of an accepted word is registered and valid in the next cycle.
// Throughput is one word per cycle while results are taken, set by the single
// result register that all frame and probe state updates feed.
// When the results side stalls, the result register holds its word and the
// items side keeps ready high only if that register is being emptied in the
// same cycle, so no word is lost or repeated.
// The configuration port writes the probe period (index 0) and the miss limit
// (index 1); writes should be made only while no word is in flight.
// Reset clears the frame parser, tick and miss counters, the alive and
// answered flags and the result valid flag, and loads a probe period of 2000
// ticks and a miss limit of 3.
module rf_frame_receiver_with_probe_unit (
	input logic clk,
	input logic arst_n,
	rffr_item_if.sink items,
	rffr_result_if.source results,
	input logic cfg_we,
	input logic cfg_index,
	input logic [15:0] cfg_data
);

	logic [15:0] period_q;
	logic [3:0] limit_q;
	logic [15:0] tick_q;
	logic [3:0] miss_q;
	logic answered_q;
	logic alive_q;

	logic res_valid_q;
	logic [2:0] event_q;
	logic alive_out_q;
	logic probe_q;
	logic lost_q;

	logic accept;
	logic is_tick;
	logic [15:0] tick_inc;
	logic probe_hit;
	logic [3:0] miss_step;
	logic lost_hit;
	logic alive_d;
	rffr_pkg::frame_ctl_t fr_ctl;
	rffr_pkg::frame_res_t fr_res;

	assign items.ready = !res_valid_q || results.ready;
	assign accept = items.valid && items.ready;
	assign is_tick = items.kind;

	assign tick_inc = tick_q + 16'd1;
	assign probe_hit = is_tick && (tick_inc >= period_q);
	assign miss_step = answered_q ? 4'd0 : ((miss_q < limit_q) ? miss_q + 4'd1 : miss_q);
	assign lost_hit = probe_hit && (miss_step >= limit_q);

	assign fr_ctl.step = accept && !is_tick;
	assign fr_ctl.abort = accept && lost_hit;

	rffr_frame u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(fr_ctl),
		.rx_byte(items.rx_byte),
		.res(fr_res)
	);

	always_comb begin
		alive_d = alive_q;
		if (is_tick) begin
			if (lost_hit) begin
				alive_d = 1'b0;
			end
		end else if (fr_res.status_ok) begin
			alive_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= rffr_pkg::PERIOD_RESET;
			limit_q <= rffr_pkg::LIMIT_RESET;
			tick_q <= 16'd0;
			miss_q <= 4'd0;
			answered_q <= 1'b0;
			alive_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rffr_pkg::REG_PROBE_PERIOD: period_q <= cfg_data;
					rffr_pkg::REG_MISS_LIMIT: limit_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (accept) begin
				alive_q <= alive_d;
				if (is_tick) begin
					if (probe_hit) begin
						tick_q <= 16'd0;
						answered_q <= 1'b0;
						miss_q <= lost_hit ? 4'd0 : miss_step;
					end else begin
						tick_q <= tick_inc;
					end
				end else if (fr_res.status_ok || fr_res.announce) begin
					answered_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			event_q <= is_tick ? 3'(rffr_pkg::EV_NONE) : 3'(fr_res.ev);
			alive_out_q <= alive_d;
			probe_q <= probe_hit;
			lost_q <= lost_hit;
		end
	end

	assign results.valid = res_valid_q;
	assign results.frame_event = event_q;
	assign results.alive = alive_out_q;
	assign results.send_probe = probe_q;
	assign results.link_lost = lost_q;

endmodule
